@@ hdl/c2d_pkg.sv @@
// shared types and constants of the 3x3 clamped convolution core
// no dependencies; every other file of the core refers to it by scoped names

package c2d_pkg;

  // field and register widths
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int TAPS       = 3;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int COEF_ROW_W = TAPS * COEF_W;

  // largest frame height the counters follow
  localparam int HEIGHT_LIMIT = 4096;

  // arithmetic widths: unsigned pixel times signed coefficient, then two adder levels
  localparam int PROD_W    = PIX_W + 1 + COEF_W;
  localparam int ROW_SUM_W = PROD_W + 2;
  localparam int SUM_W     = ROW_SUM_W + 3;

  localparam int               OFFSET_VALUE = 128;
  localparam logic [PIX_W-1:0] PIXEL_MAX    = 8'd255;

  // queue between the classifier and the datapath
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register map, in units of 8 bytes
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4,
    REG_SIGNED_MODE  = 3'd5
  } c2d_reg_t;

  // one classified pixel as it travels from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             produce;
    logic             last;
    logic [TAPS-1:0]  row_ok;
    logic [TAPS-1:0]  col_ok;
  } c2d_item_t;

  // queue status
  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QPTR_W:0] level;
  } c2d_qstat_t;

endpackage

@@ hdl/c2d_front.sv @@
// front end: accepts pixels, tracks column, row and output position, and marks
// which window taps fall inside the frame; uses c2d_pkg

module c2d_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [c2d_pkg::FW_W-1:0]            frame_width,
  input  logic [c2d_pkg::FH_W-1:0]            frame_height,
  input  logic                                in_valid,
  input  logic [c2d_pkg::PIX_W-1:0]           in_pixel,
  input  logic                                in_flush,
  output logic                                in_ready,
  input  logic                                q_full,
  output logic                                push,
  output c2d_pkg::c2d_item_t                  item,
  output logic [$clog2(MAX_WIDTH)-1:0]        idx
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = WW + 12;
  localparam int RW = PW + 1;

  logic [WW-1:0]              w_eff;
  logic [c2d_pkg::FH_W-1:0]   h_eff;
  logic [PW-1:0]              area;
  logic [CW-1:0]              col_r, col_nxt;
  logic [RW-1:0]              row_r, row_nxt;
  logic [PW-1:0]              ocnt_r, ocnt_nxt;
  logic [WW-1:0]              col_inc;
  logic [PW:0]                ocnt_inc;
  logic [WW-1:0]              cc;
  logic [RW-1:0]              rc;
  logic                       produce;
  logic                       last;

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (frame_width > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = c2d_pkg::FH_W'(1);
    end else if (frame_height > c2d_pkg::HEIGHT_LIMIT) begin
      h_eff = c2d_pkg::FH_W'(c2d_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign area = PW'(w_eff) * PW'(h_eff);

  // handshake
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // output position and frame end
  assign produce  = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
  assign ocnt_inc = {1'b0, ocnt_r} + (PW + 1)'(1);
  assign last     = produce && (ocnt_inc >= (PW + 1)'(area));
  assign col_inc  = WW'(col_r) + WW'(1);

  // centre of the window in frame coordinates
  assign cc = (col_r != '0) ? (WW'(col_r) - WW'(1)) : (w_eff - WW'(1));
  assign rc = (col_r != '0) ? (row_r - RW'(1)) : (row_r - RW'(2));

  // classified item
  always_comb begin
    item.pix       = in_flush ? '0 : in_pixel;
    item.produce   = produce;
    item.last      = last;
    item.row_ok[0] = (rc != '0) && (rc <= RW'(h_eff));
    item.row_ok[1] = rc < RW'(h_eff);
    item.row_ok[2] = ({1'b0, rc} + (RW + 1)'(1)) < (RW + 1)'(h_eff);
    item.col_ok[0] = (cc != '0) && (cc <= w_eff);
    item.col_ok[1] = cc < w_eff;
    item.col_ok[2] = ({1'b0, cc} + (WW + 1)'(1)) < {1'b0, w_eff};
  end

  assign idx = col_r;

  // counter next state
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocnt_nxt = ocnt_r;
    if (push) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        ocnt_nxt = '0;
      end else begin
        if (produce) begin
          ocnt_nxt = ocnt_inc[PW-1:0];
        end
        if (col_inc >= w_eff) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

@@ hdl/c2d_queue.sv @@
// short first-in first-out queue between the front end and the datapath
// uses c2d_pkg for its depth and status type

module c2d_queue #(
  parameter int DW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DW-1:0]       push_data,
  input  logic                pop,
  output logic [DW-1:0]       pop_data,
  output c2d_pkg::c2d_qstat_t stat
);

  logic [DW-1:0]                  slot_r [c2d_pkg::QUEUE_DEPTH];
  logic [c2d_pkg::QPTR_W-1:0]     wp_r, wp_nxt;
  logic [c2d_pkg::QPTR_W-1:0]     rp_r, rp_nxt;
  logic [c2d_pkg::QPTR_W:0]       level_r, level_nxt;

  // status
  assign stat.level = level_r;
  assign stat.full  = level_r == (c2d_pkg::QPTR_W + 1)'(c2d_pkg::QUEUE_DEPTH);
  assign stat.empty = level_r == '0;
  assign pop_data   = slot_r[rp_r];

  // pointer and level next state
  always_comb begin
    wp_nxt    = push ? wp_r + 1'b1 : wp_r;
    rp_nxt    = pop ? rp_r + 1'b1 : rp_r;
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

@@ hdl/c2d_back.sv @@
// datapath: line store, 3x3 window, nine multipliers, adder tree, clamp and
// output register; uses c2d_pkg

module c2d_back #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [c2d_pkg::COEF_ROW_W-1:0]      coef_top,
  input  logic [c2d_pkg::COEF_ROW_W-1:0]      coef_mid,
  input  logic [c2d_pkg::COEF_ROW_W-1:0]      coef_bottom,
  input  logic                                signed_mode,
  input  logic                                q_valid,
  input  c2d_pkg::c2d_item_t                  q_item,
  input  logic [$clog2(MAX_WIDTH)-1:0]        q_idx,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [c2d_pkg::PIX_W-1:0]           out_pixel,
  output logic                                out_last,
  input  logic                                out_ready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PXW = c2d_pkg::PIX_W;
  localparam int N   = c2d_pkg::TAPS;
  localparam logic signed [c2d_pkg::SUM_W-1:0] OFFSET =
    c2d_pkg::SUM_W'(c2d_pkg::OFFSET_VALUE * (2 ** COEF_FRAC_BITS));

  function automatic logic signed [c2d_pkg::PROD_W-1:0] tap_product(
    input logic [PXW-1:0]                    pix,
    input logic signed [c2d_pkg::COEF_W-1:0] coef
  );
    logic signed [c2d_pkg::PROD_W-1:0] p;
    logic signed [c2d_pkg::PROD_W-1:0] c;
    p = c2d_pkg::PROD_W'(signed'({1'b0, pix}));
    c = c2d_pkg::PROD_W'(coef);
    return p * c;
  endfunction

  logic                                  adv;
  logic [2*PXW-1:0]                      lmem [MAX_WIDTH];
  logic [2*PXW-1:0]                      rd_r;
  logic [2*PXW-1:0]                      fwd_data_r;
  logic                                  fwd_hit_r;
  logic [2*PXW-1:0]                      col_pair;
  logic [PXW-1:0]                        tap_older, tap_newer;
  logic                                  s1_v_r;
  c2d_pkg::c2d_item_t                    s1_item_r;
  logic [CW-1:0]                         s1_idx_r;
  logic [PXW-1:0]                        win_r   [N][N];
  logic [PXW-1:0]                        win_nxt [N][N];
  logic signed [c2d_pkg::COEF_W-1:0]     coef    [N][N];
  logic [c2d_pkg::COEF_ROW_W-1:0]        coef_row [N];
  logic signed [c2d_pkg::PROD_W-1:0]     prod_r  [N][N];
  logic                                  s2_v_r, s2_last_r;
  logic signed [c2d_pkg::ROW_SUM_W-1:0]  row_sum_r [N];
  logic                                  s3_v_r, s3_last_r;
  logic signed [c2d_pkg::SUM_W-1:0]      sum_r;
  logic                                  s4_v_r, s4_last_r;
  logic signed [c2d_pkg::SUM_W-1:0]      shifted;
  logic [PXW-1:0]                        clamped;
  logic                                  out_valid_r, out_last_r;
  logic [PXW-1:0]                        out_pixel_r;

  // whole datapath moves when the output register can take a result
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  // line store: one read at pop, one write when the previous item leaves stage 1
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      lmem[s1_idx_r] <= {tap_newer, s1_item_r.pix};
    end
    if (q_pop) begin
      rd_r <= lmem[q_idx];
    end
  end

  // bypass when the popped item reads the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (q_pop) begin
      fwd_hit_r <= s1_v_r && (s1_idx_r == q_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      fwd_data_r <= {tap_newer, s1_item_r.pix};
    end
  end

  assign col_pair  = fwd_hit_r ? fwd_data_r : rd_r;
  assign tap_older = col_pair[2*PXW-1:PXW];
  assign tap_newer = col_pair[PXW-1:0];

  // stage 1 holds the popped item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
      s1_idx_r  <= q_idx;
    end
  end

  // window shift with the new column
  always_comb begin
    for (int i = 0; i < N; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = tap_older;
    win_nxt[1][2] = tap_newer;
    win_nxt[2][2] = s1_item_r.pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (adv && s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  // coefficients, left tap in the low bits
  assign coef_row[0] = coef_top;
  assign coef_row[1] = coef_mid;
  assign coef_row[2] = coef_bottom;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        coef[i][j] = coef_row[i][j*c2d_pkg::COEF_W +: c2d_pkg::COEF_W];
      end
    end
  end

  // stage 2: nine products, taps outside the frame give zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_item_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      s2_last_r <= s1_item_r.last;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          if (s1_item_r.row_ok[i] && s1_item_r.col_ok[j]) begin
            prod_r[i][j] <= tap_product(win_nxt[i][j], coef[i][j]);
          end else begin
            prod_r[i][j] <= '0;
          end
        end
      end
    end
  end

  // stage 3: one sum per kernel row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r) begin
      s3_last_r <= s2_last_r;
      for (int i = 0; i < N; i++) begin
        row_sum_r[i] <= c2d_pkg::ROW_SUM_W'(prod_r[i][0])
                      + c2d_pkg::ROW_SUM_W'(prod_r[i][1])
                      + c2d_pkg::ROW_SUM_W'(prod_r[i][2]);
      end
    end
  end

  // stage 4: total plus offset in signed-kernel mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v_r) begin
      s4_last_r <= s3_last_r;
      sum_r     <= c2d_pkg::SUM_W'(row_sum_r[0])
                 + c2d_pkg::SUM_W'(row_sum_r[1])
                 + c2d_pkg::SUM_W'(row_sum_r[2])
                 + (signed_mode ? OFFSET : '0);
    end
  end

  // floor and clamp to the pixel range
  assign shifted = sum_r >>> COEF_FRAC_BITS;

  always_comb begin
    priority if (sum_r[c2d_pkg::SUM_W-1]) begin
      clamped = '0;
    end else if (shifted > c2d_pkg::SUM_W'(c2d_pkg::PIXEL_MAX)) begin
      clamped = c2d_pkg::PIXEL_MAX;
    end else begin
      clamped = shifted[PXW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_v_r) begin
      out_pixel_r <= clamped;
      out_last_r  <= s4_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

@@ hdl/conv2d_3x3_clamp_core.sv @@
// top level of the 3x3 clamped convolution core: register file, front end,
// queue and datapath; uses c2d_pkg, c2d_front, c2d_queue and c2d_back
//
//   port group   direction  transfer when               content
//   in_*         input      in_tvalid & in_tready      tdata pixel, tuser flush
//   out_*        output     out_tvalid & out_tready    tdata pixel, tlast frame end
//   p*           input      psel & penable & pwrite    register write, 8-byte stride
//
// one pixel per clock sustained while out_tready is high; a result leaves
// once the item that completes its window has passed the line store read
// and the four register stages of multiply, row add, total add and clamp
// reset is synchronous; the line store is not cleared, its unwritten entries
// only feed taps that fall outside the frame and are zeroed
// a stalled output holds the whole datapath; the four-entry queue keeps
// in_tready high through short stalls

module conv2d_3x3_clamp_core #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_in
  input  logic        in_tuser,   // [0] flush
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel_out
  output logic        out_tlast,  // frame_end
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DW = $bits(c2d_pkg::c2d_item_t) + CW;

  logic [c2d_pkg::FW_W-1:0]       frame_width_r;
  logic [c2d_pkg::FH_W-1:0]       frame_height_r;
  logic [c2d_pkg::COEF_ROW_W-1:0] coef_top_r, coef_mid_r, coef_bottom_r;
  logic                           signed_mode_r;
  logic                           wr_en;
  logic [2:0]                     reg_sel;

  logic                           front_push;
  c2d_pkg::c2d_item_t             front_item;
  logic [CW-1:0]                  front_idx;
  logic [DW-1:0]                  q_pop_data;
  c2d_pkg::c2d_qstat_t            q_stat;
  logic                           q_pop;
  c2d_pkg::c2d_item_t             q_item;
  logic [CW-1:0]                  q_idx;

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= c2d_pkg::FW_W'(1024);
      frame_height_r <= c2d_pkg::FH_W'(1024);
      coef_top_r     <= '0;
      coef_mid_r     <= c2d_pkg::COEF_ROW_W'(48'h0000_0100_0000);
      coef_bottom_r  <= '0;
      signed_mode_r  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        c2d_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[c2d_pkg::FW_W-1:0];
        c2d_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[c2d_pkg::FH_W-1:0];
        c2d_pkg::REG_COEF_TOP:     coef_top_r     <= pwdata[c2d_pkg::COEF_ROW_W-1:0];
        c2d_pkg::REG_COEF_MID:     coef_mid_r     <= pwdata[c2d_pkg::COEF_ROW_W-1:0];
        c2d_pkg::REG_COEF_BOTTOM:  coef_bottom_r  <= pwdata[c2d_pkg::COEF_ROW_W-1:0];
        c2d_pkg::REG_SIGNED_MODE:  signed_mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      c2d_pkg::REG_FRAME_WIDTH:  prdata = 64'(frame_width_r);
      c2d_pkg::REG_FRAME_HEIGHT: prdata = 64'(frame_height_r);
      c2d_pkg::REG_COEF_TOP:     prdata = 64'(coef_top_r);
      c2d_pkg::REG_COEF_MID:     prdata = 64'(coef_mid_r);
      c2d_pkg::REG_COEF_BOTTOM:  prdata = 64'(coef_bottom_r);
      c2d_pkg::REG_SIGNED_MODE:  prdata = 64'(signed_mode_r);
      default:                   prdata = '0;
    endcase
  end

  // front end
  c2d_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_valid     (in_tvalid),
    .in_pixel     (in_tdata),
    .in_flush     (in_tuser),
    .in_ready     (in_tready),
    .q_full       (q_stat.full),
    .push         (front_push),
    .item         (front_item),
    .idx          (front_idx)
  );

  // queue
  c2d_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data ({front_idx, front_item}),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  assign q_item = q_pop_data[$bits(c2d_pkg::c2d_item_t)-1:0];
  assign q_idx  = q_pop_data[DW-1:$bits(c2d_pkg::c2d_item_t)];

  // datapath
  c2d_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef_top    (coef_top_r),
    .coef_mid    (coef_mid_r),
    .coef_bottom (coef_bottom_r),
    .signed_mode (signed_mode_r),
    .q_valid     (!q_stat.empty),
    .q_item      (q_item),
    .q_idx       (q_idx),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_pixel   (out_tdata),
    .out_last    (out_tlast),
    .out_ready   (out_tready)
  );

`ifndef SYNTHESIS
  // the datapath never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // the queue level stays within its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= (c2d_pkg::QPTR_W + 1)'(c2d_pkg::QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // a frame end is only marked on an item that produces a result
  a_last_produces: assert property (@(posedge clk) disable iff (!rst_n)
    front_push && front_item.last |-> front_item.produce)
    else $error("frame end on an item without result");

  // a push into a full queue is impossible since ready follows the level
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !q_pop |=> $stable(q_stat.level) || !q_stat.full)
    else $error("queue level moved while full and not popped");
`endif

endmodule
